// File: rtl/lkvc_pkg.sv
// lkvc_pkg: shared constants and codes for the lru key-value cache
// no dependencies; imported by lru_key_value_cache
package lkvc_pkg;

   // default sizing of the entry store
   localparam int ENTRIES_DEFAULT   = 16;
   localparam int KEY_BITS_DEFAULT  = 32;
   localparam int DATA_BITS_DEFAULT = 32;

   // fixed widths of the port fields
   localparam int KEY_PORT_W  = 32;
   localparam int DATA_PORT_W = 32;
   localparam int CAP_W       = 5;

   // capacity register value after reset
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   // request commands
   typedef enum logic [0:0] {
      CMD_GET = 1'b0,
      CMD_PUT = 1'b1
   } cmd_type;

endpackage

// File: rtl/lru_key_value_cache.sv
// lru_key_value_cache: fully associative key-value cache with lru replacement
// depends on lkvc_pkg (widths, reset capacity, command codes)
//
//   channel   handshake                  beat
//   -------   ------------------------   -----------------------------------------
//   request   start & !busy              req_command, req_lookup_key, req_write_value
//   response  rsp_strobe (one cycle)     rsp_found, rsp_read_value, rsp_evicted
//   csr       csr_valid & csr_ready      csr_capacity_limit
//
// one request per clock while busy is low; the response beat passes the input
// register, then the parallel key compare and rank update into the response
// register. the compare over all entries sets the rate.
// synchronous reset clears the valid marks and occupancy and loads capacity 16;
// busy is set during reset and cleared once reset is released; csr_ready is its inverse.
// the receiver cannot stall: every response is shown for exactly one cycle.
module lru_key_value_cache
   import lkvc_pkg::*;
#(
   parameter int ENTRIES   = ENTRIES_DEFAULT,
   parameter int KEY_BITS  = KEY_BITS_DEFAULT,
   parameter int DATA_BITS = DATA_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   // request
   input  logic                   start,
   output logic                   busy,
   input  cmd_type                req_command,
   input  logic [KEY_PORT_W-1:0]  req_lookup_key,
   input  logic [DATA_PORT_W-1:0] req_write_value,
   // response
   output logic                   rsp_strobe,
   output logic                   rsp_found,
   output logic [DATA_PORT_W-1:0] rsp_read_value,
   output logic                   rsp_evicted,
   // capacity register
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CAP_W-1:0]       csr_capacity_limit
);

   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int RANK_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CMP_W  = (OCC_W > CAP_W) ? OCC_W : CAP_W;

   // control registers
   logic                 busy_ff;
   logic [CAP_W-1:0]     cap_ff,  cap_in;
   logic                 req_valid_ff;
   logic                 rsp_strobe_ff;
   logic [ENTRIES-1:0]   valid_ff, valid_in;
   logic [OCC_W-1:0]     occ_ff,   occ_in;

   // request register
   cmd_type              req_cmd_ff;
   logic [KEY_BITS-1:0]  req_key_ff;
   logic [DATA_BITS-1:0] req_data_ff;

   // entry store
   logic [KEY_BITS-1:0]  key_ff  [ENTRIES];
   logic [KEY_BITS-1:0]  key_in  [ENTRIES];
   logic [DATA_BITS-1:0] data_ff [ENTRIES];
   logic [DATA_BITS-1:0] data_in [ENTRIES];
   logic [RANK_W-1:0]    rank_ff [ENTRIES];
   logic [RANK_W-1:0]    rank_in [ENTRIES];

   // response register
   logic                   rsp_found_ff,   rsp_found_in;
   logic [DATA_PORT_W-1:0] rsp_value_ff,   rsp_value_in;
   logic                   rsp_evicted_ff, rsp_evicted_in;

   // lookup and replacement decode
   logic [ENTRIES-1:0]   hit_vec, hit_first, free_first, victim_vec, target_vec;
   logic                 any_hit, room, is_put, touch, do_insert, do_evict;
   logic [DATA_BITS-1:0] hit_data;
   logic [RANK_W-1:0]    hit_rank;
   logic [OCC_W-1:0]     age_limit;
   logic [CMP_W-1:0]     cap_eff;

   assign busy       = busy_ff;
   assign csr_ready  = !busy_ff;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_read_value = rsp_value_ff;
   assign rsp_evicted    = rsp_evicted_ff;

   // capacity register write
   assign cap_in = (csr_valid && csr_ready) ? csr_capacity_limit : cap_ff;

   // parallel compare, free slot and lru victim
   always_comb begin
      hit_data = '0;
      hit_rank = '0;
      for (int j = 0; j < ENTRIES; j++) begin
         hit_vec[j]    = valid_ff[j] && (key_ff[j] == req_key_ff);
         victim_vec[j] = valid_ff[j] && (OCC_W'(rank_ff[j]) == (occ_ff - OCC_W'(1)));
      end
      hit_first  = hit_vec & (~hit_vec + ENTRIES'(1));
      free_first = ~valid_ff & (valid_ff + ENTRIES'(1));
      for (int j = 0; j < ENTRIES; j++) begin
         if (hit_first[j]) begin
            hit_data = hit_data | data_ff[j];
            hit_rank = hit_rank | rank_ff[j];
         end
      end
      any_hit = |hit_vec;

      // effective capacity clamped to one .. ENTRIES
      cap_eff = (cap_ff == '0) ? CMP_W'(1) : CMP_W'(cap_ff);
      room    = (CMP_W'(occ_ff) < cap_eff) && (occ_ff < OCC_W'(ENTRIES));

      is_put    = (req_cmd_ff == CMD_PUT);
      touch     = req_valid_ff && (any_hit || is_put);
      do_insert = req_valid_ff && is_put && !any_hit && room;
      do_evict  = req_valid_ff && is_put && !any_hit && !room;

      // target entry and the rank below which entries age by one
      if (any_hit) begin
         target_vec = hit_first;
         age_limit  = OCC_W'(hit_rank);
      end else if (room) begin
         target_vec = free_first;
         age_limit  = occ_ff;
      end else begin
         target_vec = victim_vec;
         age_limit  = occ_ff - OCC_W'(1);
      end
   end

   // next entry state
   always_comb begin
      valid_in = valid_ff;
      occ_in   = occ_ff;
      for (int j = 0; j < ENTRIES; j++) begin
         key_in[j]  = key_ff[j];
         data_in[j] = data_ff[j];
         rank_in[j] = rank_ff[j];
         if (touch) begin
            if (target_vec[j]) begin
               rank_in[j] = '0;
            end else if (valid_ff[j] && (OCC_W'(rank_ff[j]) < age_limit)) begin
               rank_in[j] = rank_ff[j] + RANK_W'(1);
            end
         end
         if (req_valid_ff && is_put && target_vec[j]) begin
            data_in[j] = req_data_ff;
            if (!any_hit) begin
               key_in[j] = req_key_ff;
            end
         end
      end
      if (do_insert) begin
         valid_in = valid_ff | target_vec;
         occ_in   = occ_ff + OCC_W'(1);
      end
   end

   // response beat
   always_comb begin
      rsp_found_in   = any_hit;
      rsp_evicted_in = do_evict;
      if (any_hit && !is_put) begin
         rsp_value_in = DATA_PORT_W'({{DATA_PORT_W{1'b0}}, hit_data});
      end else begin
         rsp_value_in = '0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b1;
         cap_ff        <= CAP_RESET;
         req_valid_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
      end else begin
         busy_ff       <= 1'b0;
         cap_ff        <= cap_in;
         req_valid_ff  <= start && !busy_ff;
         rsp_strobe_ff <= req_valid_ff;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
      end
   end

   // request and response payload, entry store
   always_ff @(posedge clock) begin
      req_cmd_ff     <= req_command;
      req_key_ff     <= KEY_BITS'({{KEY_BITS{1'b0}}, req_lookup_key});
      req_data_ff    <= DATA_BITS'({{DATA_BITS{1'b0}}, req_write_value});
      rsp_found_ff   <= rsp_found_in;
      rsp_value_ff   <= rsp_value_in;
      rsp_evicted_ff <= rsp_evicted_in;
      for (int j = 0; j < ENTRIES; j++) begin
         key_ff[j]  <= key_in[j];
         data_ff[j] <= data_in[j];
         rank_ff[j] <= rank_in[j];
      end
   end

endmodule

// File: bench/testbench.sv
// testbench for lru_key_value_cache: self-checking run of gets and puts over several capacities
// depends on lkvc_pkg and the lru_key_value_cache rtl; the expected beats come from an lru tracker
`timescale 1ns / 100ps

module testbench
   import lkvc_pkg::*;
;

   localparam int SLOTS       = ENTRIES_DEFAULT;
   localparam int CYCLE_LIMIT = 200000;
   localparam int REPORT_MAX  = 10;
   localparam int POOL_SIZE   = 24;

   typedef struct packed {
      logic                   found;
      logic [DATA_PORT_W-1:0] read_value;
      logic                   evicted;
   } cache_reply_type;

   // lru tracker: mirror of the entry store plus the replies still owed
   class lru_tracker_type;
      logic                   slot_valid [SLOTS];
      logic [KEY_PORT_W-1:0]  slot_key   [SLOTS];
      logic [DATA_PORT_W-1:0] slot_data  [SLOTS];
      logic [3:0]             slot_age   [SLOTS];
      logic [CAP_W-1:0]       fill;
      logic [CAP_W-1:0]       capacity;
      cache_reply_type        owed_replies[$];
      int                     error_count;

      function new();
         for (int j = 0; j < SLOTS; j++) begin
            slot_valid[j] = 1'b0;
            slot_key[j]   = '0;
            slot_data[j]  = '0;
            slot_age[j]   = '0;
         end
         fill        = '0;
         capacity    = CAP_RESET;
         error_count = 0;
      endfunction

      function void set_capacity(logic [CAP_W-1:0] value);
         capacity = value;
      endfunction

      function int outstanding();
         return owed_replies.size();
      endfunction

      function void flag_error(string msg);
         error_count++;
         if (error_count <= REPORT_MAX)
            $display("[%0t] %s", $realtime, msg);
      endfunction

      // zero and oversized capacities clamp to one and to the store size
      function logic [CAP_W-1:0] usable_capacity();
         if (capacity == 0)
            return CAP_W'(1);
         if (capacity > SLOTS)
            return CAP_W'(SLOTS);
         return capacity;
      endfunction

      // slot s becomes most recent, the ones more recent than it age by one
      function void promote(int s);
         logic [3:0] age_s;
         age_s = slot_age[s];
         for (int j = 0; j < SLOTS; j++)
            if (slot_valid[j] && j != s && slot_age[j] < age_s)
               slot_age[j]++;
         slot_age[s] = '0;
      endfunction

      // accepted request beat: update the mirror and queue the reply it owes
      function void note_request(cmd_type cmd, logic [KEY_PORT_W-1:0] key,
                                 logic [DATA_PORT_W-1:0] value);
         cache_reply_type reply;
         int              hit_slot;
         int              slot;
         logic [3:0]      oldest;
         bit              any;
         reply    = '0;
         hit_slot = -1;
         slot     = 0;
         oldest   = '0;
         any      = 0;
         for (int j = 0; j < SLOTS; j++)
            if (hit_slot < 0 && slot_valid[j] && slot_key[j] == key)
               hit_slot = j;
         if (hit_slot >= 0) begin
            reply.found = 1'b1;
            promote(hit_slot);
            if (cmd == CMD_PUT)
               slot_data[hit_slot] = value;
            else
               reply.read_value = slot_data[hit_slot];
         end else if (cmd == CMD_PUT) begin
            if (fill < usable_capacity()) begin
               // insert into the first free slot, everything else ages
               slot = -1;
               for (int j = 0; j < SLOTS; j++)
                  if (slot < 0 && !slot_valid[j])
                     slot = j;
               for (int j = 0; j < SLOTS; j++)
                  if (slot_valid[j])
                     slot_age[j]++;
               slot_valid[slot] = 1'b1;
               slot_age[slot]   = '0;
               fill++;
            end else begin
               // replace the least recent entry
               for (int j = 0; j < SLOTS; j++)
                  if (slot_valid[j] && (!any || slot_age[j] > oldest)) begin
                     oldest = slot_age[j];
                     slot   = j;
                     any    = 1;
                  end
               promote(slot);
               reply.evicted = 1'b1;
            end
            slot_key[slot]  = key;
            slot_data[slot] = value;
         end
         owed_replies.push_back(reply);
      endfunction

      // response beat: compare against the oldest owed reply
      function void check_response(logic found, logic [DATA_PORT_W-1:0] read_value,
                                   logic evicted);
         cache_reply_type want;
         if (owed_replies.size() == 0) begin
            flag_error($sformatf("unexpected response: found=%0b read_value=%h evicted=%0b",
                                 found, read_value, evicted));
            return;
         end
         want = owed_replies.pop_front();
         if (found !== want.found || read_value !== want.read_value ||
             evicted !== want.evicted)
            flag_error($sformatf({"mismatch: found exp %0b got %0b, read_value exp %h got %h,",
                                  " evicted exp %0b got %0b"},
                                 want.found, found, want.read_value, read_value,
                                 want.evicted, evicted));
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   start;
   logic                   busy;
   cmd_type                req_command;
   logic [KEY_PORT_W-1:0]  req_lookup_key;
   logic [DATA_PORT_W-1:0] req_write_value;
   logic                   rsp_strobe;
   logic                   rsp_found;
   logic [DATA_PORT_W-1:0] rsp_read_value;
   logic                   rsp_evicted;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CAP_W-1:0]       csr_capacity_limit;

   lru_tracker_type        tracker = new();
   logic [KEY_PORT_W-1:0]  key_pool [POOL_SIZE];
   int                     cycle_count = 0;

   lru_key_value_cache u_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_command        (req_command),
      .req_lookup_key     (req_lookup_key),
      .req_write_value    (req_write_value),
      .rsp_strobe         (rsp_strobe),
      .rsp_found          (rsp_found),
      .rsp_read_value     (rsp_read_value),
      .rsp_evicted        (rsp_evicted),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_capacity_limit (csr_capacity_limit)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // response monitor, sampled on the rising edge
   always @(posedge clock) begin
      if (!reset && rsp_strobe)
         tracker.check_response(rsp_found, rsp_read_value, rsp_evicted);
   end

   // one request beat; entered and left on a falling edge
   task automatic issue_request(cmd_type cmd, logic [KEY_PORT_W-1:0] key,
                                logic [DATA_PORT_W-1:0] value);
      start           = 1'b1;
      req_command     = cmd;
      req_lookup_key  = key;
      req_write_value = value;
      do
         @(posedge clock);
      while (busy);
      tracker.note_request(cmd, key, value);
      @(negedge clock);
   endtask

   // stop sending and wait until every owed reply has come back
   task automatic drain_replies();
      start = 1'b0;
      while (tracker.outstanding() != 0)
         @(negedge clock);
   endtask

   // capacity write, only with the cache idle
   task automatic load_capacity(logic [CAP_W-1:0] value);
      drain_replies();
      repeat (3) @(negedge clock);
      csr_valid          = 1'b1;
      csr_capacity_limit = value;
      do
         @(posedge clock);
      while (!csr_ready);
      tracker.set_capacity(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // bursts of random requests over a pool of keys, with random gaps
   task automatic run_random_phase(int count, int span);
      int                     sent;
      int                     burst;
      cmd_type                cmd;
      logic [KEY_PORT_W-1:0]  key;
      logic [DATA_PORT_W-1:0] value;
      sent = 0;
      while (sent < count) begin
         burst = $urandom_range(1, 24);
         for (int b = 0; b < burst && sent < count; b++) begin
            cmd = $urandom_range(0, 1) ? CMD_PUT : CMD_GET;
            if ($urandom_range(0, 9) == 0)
               key = $urandom;
            else
               key = key_pool[$urandom_range(0, span - 1)];
            case ($urandom_range(0, 7))
               0:       value = 32'h8000_0000;
               1:       value = 32'h7fff_ffff;
               2:       value = 32'h0000_0000;
               3:       value = 32'hffff_ffff;
               default: value = $urandom;
            endcase
            issue_request(cmd, key, value);
            sent++;
         end
         start = 1'b0;
         if ($urandom_range(0, 29) == 0)
            drain_replies();
         else if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      start = 1'b0;
   endtask

   initial begin
      int phase_cap  [12];
      int phase_span [12];
      int settle;

      phase_cap          = '{6, 10, 31, 17, 16, 2, 1, 0, 12, 16, 8, 24};
      phase_span         = '{10, 14, 24, 22, 24, 6, 4, 4, 18, 24, 12, 24};
      reset              = 1'b1;
      start              = 1'b0;
      req_command        = CMD_GET;
      req_lookup_key     = '0;
      req_write_value    = '0;
      csr_valid          = 1'b0;
      csr_capacity_limit = '0;
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = $urandom;
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      // capacity zero behaves as one: the second insert replaces the first
      load_capacity(5'd0);
      issue_request(CMD_GET, 32'h0000_0000, 32'hffff_ffff);
      issue_request(CMD_PUT, 32'h8000_0000, 32'h7fff_ffff);
      issue_request(CMD_PUT, 32'h7fff_ffff, 32'h8000_0000);
      issue_request(CMD_GET, 32'h8000_0000, 32'h0000_0000);
      issue_request(CMD_GET, 32'h7fff_ffff, 32'h0000_0000);

      // capacity one: replace, then overwrite a present key
      load_capacity(5'd1);
      issue_request(CMD_PUT, 32'hffff_ffff, 32'hffff_ffff);
      issue_request(CMD_PUT, 32'hffff_ffff, 32'h0000_0000);
      issue_request(CMD_GET, 32'hffff_ffff, 32'h1234_5678);

      // capacity four: fill, refresh the oldest, then push out the least recent
      load_capacity(5'd4);
      issue_request(CMD_PUT, 32'h0000_0000, 32'h0000_0000);
      issue_request(CMD_PUT, 32'h0000_0001, 32'ha5a5_a5a5);
      issue_request(CMD_PUT, 32'h0000_0002, 32'h5a5a_5a5a);
      issue_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
      issue_request(CMD_PUT, 32'h0000_0003, 32'h8000_0000);
      issue_request(CMD_GET, 32'h0000_0000, 32'h0000_0000);
      issue_request(CMD_GET, 32'hffff_ffff, 32'h0000_0000);
      issue_request(CMD_PUT, 32'h0000_0001, 32'h7fff_ffff);
      issue_request(CMD_PUT, 32'h8000_0000, 32'hffff_ffff);
      issue_request(CMD_GET, 32'h0000_0002, 32'h0000_0000);
      issue_request(CMD_GET, 32'h0000_0001, 32'h0000_0000);
      start = 1'b0;

      // random phases; capacity is lowered below the fill level late in the run
      for (int p = 0; p < 12; p++) begin
         load_capacity(CAP_W'(phase_cap[p]));
         run_random_phase(90, phase_span[p]);
      end

      // wind down: wait for owed replies, then a short settle window
      drain_replies();
      settle = 0;
      while (settle < 10) begin
         @(negedge clock);
         settle++;
      end
      if (tracker.outstanding() != 0) begin
         tracker.flag_error($sformatf("missing responses: %0d", tracker.outstanding()));
      end
      if (tracker.error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
